// ===== rtl/ipv4dp_pkg.sv =====
`default_nettype none

package ipv4dp_pkg;

   localparam int CHAR_W   = 8;
   localparam int FIELD_W  = 10;
   localparam int COUNT_W  = 2;
   localparam int OCTETS_W = 24;
   localparam int ADDR_W   = 32;

   localparam logic [CHAR_W-1:0]  DOT_CHAR   = 8'h2E;
   localparam logic [CHAR_W-1:0]  DIGIT_BASE = 8'd48;
   localparam logic [CHAR_W-1:0]  DIGIT_TOP  = 8'd57;
   localparam logic [COUNT_W-1:0] MAX_DIGITS = 2'd3;
   localparam logic [COUNT_W-1:0] MAX_DOTS   = 2'd3;

   // one character as it leaves the input register
   typedef struct packed {
      logic              step;
      logic [CHAR_W-1:0] character;
      logic              is_last;
   } item_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic              ok;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/ipv4dp_req_if.sv =====
`default_nettype none

interface ipv4dp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       is_last;

   modport source (output valid, output character, output is_last, input ready);
   modport sink   (input valid, input character, input is_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/ipv4dp_rsp_if.sv =====
`default_nettype none

interface ipv4dp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] address;
   logic        ok;

   modport source (output valid, output address, output ok, input ready);
   modport sink   (input valid, input address, input ok, output ready);
endinterface

`default_nettype wire

// ===== rtl/ipv4_dotted_decimal_parser.sv =====
// Dotted-decimal IPv4 string to 32-bit address.
//
// req_chan carries one ASCII character per item, with is_last set on the
// final character of the string. rsp_chan returns one item per string,
// issued for the item marked is_last: the address (first octet in bits
// 31..24) and ok. A malformed string (wrong dot count, an empty field or
// one with more than three digits, any character that is not a digit or a
// dot) gives address 0 with ok clear. A field above 255 keeps its low 8 bits.
//
// Throughput is one character per cycle, save that a final character
// waits while the output register is full and stalled. Each character is
// held in the input register, then the field/dot update and the result
// are worked out in a single pass into the output register.
// If rsp_chan stalls, the input register still passes non-final characters
// on; only a final character waits for the output register to drain.
// Synchronous reset empties both registers and clears the string state.
`default_nettype none

module ipv4_dotted_decimal_parser (
   input wire logic     clock,
   input wire logic     reset,
   ipv4dp_req_if.sink   req_chan,
   ipv4dp_rsp_if.source rsp_chan
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_char_ff;
   logic                  in_last_ff;
   logic                  out_valid_ff, out_valid_in;
   ipv4dp_pkg::result_type out_ff;

   logic                   out_free;
   logic                   in_go;
   logic                   req_take;
   ipv4dp_pkg::item_type   item;
   ipv4dp_pkg::result_type result;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign in_go    = in_valid_ff && (!in_last_ff || out_free);
   assign req_chan.ready = !in_valid_ff || in_go;
   assign req_take = req_chan.valid && req_chan.ready;

   assign item.step      = in_go;
   assign item.character = in_char_ff;
   assign item.is_last   = in_last_ff;

   ipv4dp_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .item   (item),
      .result (result)
   );

   assign in_valid_in  = req_take || (in_valid_ff && !in_go);
   assign out_valid_in = (out_valid_ff && !rsp_chan.ready) || (in_go && in_last_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_chan.character;
         in_last_ff <= req_chan.is_last;
      end
      if (in_go && in_last_ff) begin
         out_ff <= result;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.address = out_ff.address;
   assign rsp_chan.ok      = out_ff.ok;

endmodule

`default_nettype wire

// ===== rtl/ipv4dp_parse.sv =====
`default_nettype none

module ipv4dp_parse (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ipv4dp_pkg::item_type   item,
   output ipv4dp_pkg::result_type      result
);

   logic [ipv4dp_pkg::FIELD_W-1:0]  field_ff,  field_in;
   logic [ipv4dp_pkg::COUNT_W-1:0]  digits_ff, digits_in;
   logic [ipv4dp_pkg::COUNT_W-1:0]  dots_ff,   dots_in;
   logic [ipv4dp_pkg::OCTETS_W-1:0] octets_ff, octets_in;
   logic                            bad_ff,    bad_in;

   logic                            is_digit;
   logic                            is_dot;
   logic [ipv4dp_pkg::CHAR_W-1:0]   char_off;
   logic [12:0]                     times_ten;
   logic [12:0]                     field_sum;
   logic                            good;

   assign is_digit  = (item.character >= ipv4dp_pkg::DIGIT_BASE) &&
                      (item.character <= ipv4dp_pkg::DIGIT_TOP);
   assign is_dot    = (item.character == ipv4dp_pkg::DOT_CHAR);
   assign char_off  = item.character - ipv4dp_pkg::DIGIT_BASE;
   // x*10 as x*8 + x*2
   assign times_ten = {field_ff, 3'b000} + {2'b00, field_ff, 1'b0};
   assign field_sum = times_ten + {9'd0, char_off[3:0]};

   always_comb begin
      field_in  = field_ff;
      digits_in = digits_ff;
      dots_in   = dots_ff;
      octets_in = octets_ff;
      bad_in    = bad_ff;
      // once malformed, nothing moves until the last item
      if (!bad_ff) begin
         if (is_digit) begin
            if (digits_ff == ipv4dp_pkg::MAX_DIGITS) begin
               bad_in = 1'b1;
            end else begin
               field_in  = field_sum[ipv4dp_pkg::FIELD_W-1:0];
               digits_in = digits_ff + 2'd1;
            end
         end else if (is_dot) begin
            if ((digits_ff == 2'd0) || (dots_ff == ipv4dp_pkg::MAX_DOTS)) begin
               bad_in = 1'b1;
            end else begin
               octets_in = {octets_ff[15:0], field_ff[7:0]};
               dots_in   = dots_ff + 2'd1;
               field_in  = '0;
               digits_in = '0;
            end
         end else begin
            bad_in = 1'b1;
         end
      end
   end

   assign good           = !bad_in && (dots_in == ipv4dp_pkg::MAX_DOTS) && (digits_in != 2'd0);
   assign result.ok      = good;
   assign result.address = good ? {octets_in, field_in[7:0]} : '0;

   always_ff @(posedge clock) begin
      if (reset || (item.step && item.is_last)) begin
         field_ff  <= '0;
         digits_ff <= '0;
         dots_ff   <= '0;
         octets_ff <= '0;
         bad_ff    <= 1'b0;
      end else if (item.step) begin
         field_ff  <= field_in;
         digits_ff <= digits_in;
         dots_ff   <= dots_in;
         octets_ff <= octets_in;
         bad_ff    <= bad_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ipv4dp_checker.sv =====
`default_nettype none

module ipv4dp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_is_last,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_address,
   input wire logic        rsp_ok
);

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_address) && $stable(rsp_ok))
      else $error("stalled result changed");

   // rejected strings report address zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_address == 32'd0)
      else $error("rejected string with non-zero address");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // a fresh result follows the acceptance of a final character
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_is_last, 2))
      else $error("result without a final character");

endmodule

bind ipv4_dotted_decimal_parser ipv4dp_checker u_ipv4dp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_is_last (req_chan.is_last),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_address (rsp_chan.address),
   .rsp_ok      (rsp_chan.ok)
);

`default_nettype wire
